/* sv/indexed_max_priority_queue_macros.svh */
// Assertion helpers shared by the priority queue RTL.
// Every assertion samples on clk and is disabled while rst is high.
`ifndef INDEXED_MAX_PRIORITY_QUEUE_MACROS_SVH
`define INDEXED_MAX_PRIORITY_QUEUE_MACROS_SVH

// Same-cycle implication.
`define IMQ_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define IMQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/imq_pkg.sv */
// ----------------------------------------------------------------------------
// imq_pkg
// Shared constants, operation and status codes, and the control bundle
// that the sequencer sends to the row of heap slot cells.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package imq_pkg;

  localparam int ITEM_W      = 4;   // item index width
  localparam int ITEM_LIMIT  = 16;  // items addressable by ITEM_W bits
  localparam int PRIO_IN_W   = 16;  // priority field width on the input
  localparam int FUNC_W      = 2;
  localparam int STATUS_W    = 2;
  localparam int COUNT_OUT_W = 5;
  localparam int S_DATA_W    = 24;
  localparam int M_DATA_W    = 16;

  localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_DELETE = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_CHANGE = 2'd2;

  localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY    = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_CONFLICT = 2'd3;

  typedef struct packed {
    logic start_ins;  // load new item into slot count+1, token there
    logic start_del;  // slot 1 takes the last slot's entry, token there
    logic start_chg;  // matching slot takes the new priority, token there
    logic up;         // sift-up step this cycle
    logic dn;         // sift-down step this cycle
  } cell_ctl_t;

endpackage

/* sv/imq_cell.sv */
// ----------------------------------------------------------------------------
// imq_cell
// One heap slot: holds an item index and its priority, plus the token bit
// that marks the slot under sift. Compares with its parent or children and
// swaps entries with them, handing the token along.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "indexed_max_priority_queue_macros.svh"

module imq_cell #(
  parameter int SLOT  = 1,
  parameter int ITEMS = 16,
  parameter int PW    = 16,
  localparam int CW   = $clog2(ITEMS + 1)
) (
  input  logic                        clk,
  input  logic                        rst,
  input  imq_pkg::cell_ctl_t          ctl,
  input  logic [CW-1:0]               n,
  input  logic [imq_pkg::ITEM_W-1:0]  new_item,
  input  logic signed [PW-1:0]        new_prio,
  input  logic [imq_pkg::ITEM_W-1:0]  last_item_bus,
  input  logic signed [PW-1:0]        last_prio_bus,
  input  logic [imq_pkg::ITEM_W-1:0]  parent_item,
  input  logic signed [PW-1:0]        parent_prio,
  input  logic                        parent_dn_swap,
  input  logic [imq_pkg::ITEM_W-1:0]  left_item,
  input  logic signed [PW-1:0]        left_prio,
  input  logic                        left_up_swap,
  input  logic [imq_pkg::ITEM_W-1:0]  right_item,
  input  logic signed [PW-1:0]        right_prio,
  input  logic                        right_up_swap,
  output logic [imq_pkg::ITEM_W-1:0]  item,
  output logic signed [PW-1:0]        prio,
  output logic                        tok,
  output logic                        hit,
  output logic                        stop,
  output logic                        up_swap,
  output logic                        dn_swap_l,
  output logic                        dn_swap_r,
  output logic [imq_pkg::ITEM_W-1:0]  last_item,
  output logic signed [PW-1:0]        last_prio
);

  import imq_pkg::*;

  localparam bit HAS_P = (SLOT > 1);
  localparam bit HAS_L = (2 * SLOT <= ITEMS);
  localparam bit HAS_R = (2 * SLOT + 1 <= ITEMS);
  localparam logic [CW-1:0] S_VAL = CW'(SLOT);
  localparam logic [CW-1:0] P_VAL = CW'(SLOT - 1);
  localparam logic [CW-1:0] L_VAL = HAS_L ? CW'(2 * SLOT) : '0;
  localparam logic [CW-1:0] R_VAL = HAS_R ? CW'(2 * SLOT + 1) : '0;

  logic [ITEM_W-1:0]   item_next;
  logic signed [PW-1:0] prio_next;
  logic                tok_next;
  logic                occupied;
  logic                dn_has;
  logic                pick_r;
  logic signed [PW-1:0] child_prio;
  logic                dn_go;

  assign occupied   = (n >= S_VAL);
  assign hit        = occupied && (item == new_item);
  assign dn_has     = HAS_L && (n >= L_VAL);
  // right child wins only when strictly greater than the left child
  assign pick_r     = HAS_R && (n >= R_VAL) && (left_prio < right_prio);
  assign child_prio = pick_r ? right_prio : left_prio;

  assign up_swap   = ctl.up && tok && HAS_P && (parent_prio < prio);
  assign dn_go     = ctl.dn && tok && dn_has && (prio < child_prio);
  assign dn_swap_l = dn_go && !pick_r;
  assign dn_swap_r = dn_go && pick_r;
  assign stop      = tok && (ctl.up || ctl.dn) && !up_swap && !dn_go;

  assign last_item = (n == S_VAL) ? item : '0;
  assign last_prio = (n == S_VAL) ? prio : '0;

  always_comb begin
    item_next = item;
    prio_next = prio;
    tok_next  = tok;
    if (ctl.start_ins || ctl.start_del || ctl.start_chg) begin
      tok_next = 1'b0;
    end
    if (ctl.start_ins && (n == P_VAL)) begin
      item_next = new_item;
      prio_next = new_prio;
      tok_next  = 1'b1;
    end
    if (ctl.start_del && !HAS_P) begin
      item_next = last_item_bus;
      prio_next = last_prio_bus;
      tok_next  = 1'b1;
    end
    if (ctl.start_chg && hit) begin
      prio_next = new_prio;
      tok_next  = 1'b1;
    end
    // at most one swap touches this slot per cycle
    if (up_swap || parent_dn_swap) begin
      item_next = parent_item;
      prio_next = parent_prio;
      tok_next  = parent_dn_swap;
    end
    if (dn_swap_l || left_up_swap) begin
      item_next = left_item;
      prio_next = left_prio;
      tok_next  = left_up_swap;
    end
    if (dn_swap_r || right_up_swap) begin
      item_next = right_item;
      prio_next = right_prio;
      tok_next  = right_up_swap;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok <= 1'b0;
    end else begin
      tok <= tok_next;
    end
  end

  always_ff @(posedge clk) begin
    item <= item_next;
    prio <= prio_next;
  end

endmodule

/* sv/imq_ctrl.sv */
// ----------------------------------------------------------------------------
// imq_ctrl
// Operation sequencer: decodes a transaction, checks full, empty and
// presence, starts the slot cells, steps sift-up and sift-down until the
// token stops, and holds the result in the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "indexed_max_priority_queue_macros.svh"

module imq_ctrl #(
  parameter int ITEMS    = 16,
  parameter int CAPACITY = 16,
  localparam int CW      = $clog2(ITEMS + 1)
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [imq_pkg::FUNC_W-1:0]       in_func,
  input  logic [imq_pkg::ITEM_W-1:0]       in_item,
  input  logic                             any_hit,
  input  logic                             any_stop,
  input  logic [imq_pkg::ITEM_W-1:0]       top_item,
  output imq_pkg::cell_ctl_t               ctl,
  output logic [CW-1:0]                    count,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [imq_pkg::STATUS_W-1:0]     out_status,
  output logic [imq_pkg::ITEM_W-1:0]       out_removed,
  output logic [imq_pkg::COUNT_OUT_W-1:0]  out_count,
  output logic                             out_empty
);

  import imq_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_UP   = 2'd1;
  localparam logic [1:0] ST_DN   = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0]          state, state_next;
  logic                chg;
  logic [STATUS_W-1:0] status_r;
  logic [ITEM_W-1:0]   removed_r;
  logic                acc;
  logic                full;
  logic                item_ok;
  logic                present;
  logic                ins_ok, del_ok, chg_ok;
  logic [STATUS_W-1:0] status;
  logic                out_free;

  assign in_ready = (state == ST_IDLE);
  assign acc      = in_valid && in_ready;
  // a capacity above the nameable items can never fill up
  assign full     = (CAPACITY <= ITEM_LIMIT) && (count >= CW'(ITEMS));
  assign item_ok  = (int'(in_item) < ITEMS);
  assign present  = item_ok && any_hit;
  assign out_free = !out_valid || out_ready;

  always_comb begin
    status = STATUS_OK;
    ins_ok = 1'b0;
    del_ok = 1'b0;
    chg_ok = 1'b0;
    unique case (in_func)
      FUNC_INSERT: begin
        if (full) begin
          status = STATUS_FULL;
        end else if (!item_ok || present) begin
          status = STATUS_CONFLICT;
        end else begin
          ins_ok = 1'b1;
        end
      end
      FUNC_DELETE: begin
        if (count == '0) begin
          status = STATUS_EMPTY;
        end else begin
          del_ok = 1'b1;
        end
      end
      FUNC_CHANGE: begin
        if (!present) begin
          status = STATUS_CONFLICT;
        end else begin
          chg_ok = 1'b1;
        end
      end
      default: begin
        status = STATUS_OK;
      end
    endcase
  end

  assign ctl.start_ins = acc && ins_ok;
  assign ctl.start_del = acc && del_ok;
  assign ctl.start_chg = acc && chg_ok;
  assign ctl.up        = (state == ST_UP);
  assign ctl.dn        = (state == ST_DN);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (acc) begin
          if (ins_ok || chg_ok) begin
            state_next = ST_UP;
          end else if (del_ok) begin
            state_next = ST_DN;
          end else begin
            state_next = ST_DONE;
          end
        end
      end
      ST_UP: begin
        // a change sifts down from wherever the item settled
        if (any_stop) begin
          state_next = chg ? ST_DN : ST_DONE;
        end
      end
      ST_DN: begin
        if (any_stop) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (ctl.start_ins) begin
        count <= count + 1'b1;
      end else if (ctl.start_del) begin
        count <= count - 1'b1;
      end
      if ((state == ST_DONE) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      chg       <= chg_ok;
      status_r  <= status;
      removed_r <= del_ok ? top_item : '0;
    end
    if ((state == ST_DONE) && out_free) begin
      out_status  <= status_r;
      out_removed <= removed_r;
      out_count   <= COUNT_OUT_W'(count);
      out_empty   <= (count == '0);
    end
  end

  `IMQ_ASSERT(a_count_max, 1'b1, count <= CW'(ITEMS), "queue count above capacity")
  `IMQ_ASSERT(a_up_nonempty, state == ST_UP, count != '0, "sift-up on empty queue")
  `IMQ_ASSERT_NEXT(a_del_count, ctl.start_del, count == $past(count) - 1'b1,
    "delete did not lower count")

endmodule

/* sv/indexed_max_priority_queue.sv */
// ----------------------------------------------------------------------------
// indexed_max_priority_queue
// Indexed max-priority queue kept as a binary heap in a row of slot cells.
//
// Input channel s_axis: one transaction per operation. tuser carries the
// operation (insert, delete max, change priority); tdata carries the item
// index and the requested priority. Output channel m_axis: one transaction
// per operation with status, the removed item, the entry count and an
// empty flag.
// One operation is in flight at a time. The accept cycle decodes and loads
// the cells, then one compare-swap level per cycle, then ST_DONE writes
// the output register once it is free: insert sifts up, delete sifts down,
// change sifts up and then down, and rejected operations skip the sift.
// The heap has at most 16 slots, walked by a single token one level per
// cycle.
// A result waiting in the output register does not block the next
// operation; only its own write waits for m_axis_tready.
// Synchronous reset empties the queue; no clearing pass is needed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "indexed_max_priority_queue_macros.svh"

module indexed_max_priority_queue #(
  parameter int CAPACITY      = 16,
  parameter int PRIORITY_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // [3:0] item_index, [19:4] priority_req, [23:20] zero
  input  logic [imq_pkg::S_DATA_W-1:0]   s_axis_tdata,
  // [1:0] func
  input  logic [imq_pkg::FUNC_W-1:0]     s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // [3:0] removed_index, [8:4] entry_count, [9] is_empty, [15:10] zero
  output logic [imq_pkg::M_DATA_W-1:0]   m_axis_tdata,
  // [1:0] status
  output logic [imq_pkg::STATUS_W-1:0]   m_axis_tuser
);

  import imq_pkg::*;

  localparam int ITEMS = (CAPACITY < ITEM_LIMIT) ? CAPACITY : ITEM_LIMIT;
  localparam int PW    = (PRIORITY_BITS < PRIO_IN_W) ? PRIORITY_BITS : PRIO_IN_W;
  localparam int CW    = $clog2(ITEMS + 1);

  cell_ctl_t             ctl;
  logic [CW-1:0]         count;
  logic [ITEM_W-1:0]     new_item;
  logic signed [PW-1:0]  new_prio;
  logic [ITEM_W-1:0]     last_item_bus;
  logic signed [PW-1:0]  last_prio_bus;
  logic                  any_hit;
  logic                  any_stop;
  logic [ITEMS-1:0]      tok_v;
  logic [ITEMS-1:0]      hit_v;
  logic [ITEMS-1:0]      stop_v;

  logic [ITEM_W-1:0]     item_a      [1:ITEMS];
  logic signed [PW-1:0]  prio_a      [1:ITEMS];
  logic                  up_a        [1:ITEMS];
  logic                  dnl_a       [1:ITEMS];
  logic                  dnr_a       [1:ITEMS];
  logic [ITEM_W-1:0]     last_item_a [1:ITEMS];
  logic signed [PW-1:0]  last_prio_a [1:ITEMS];

  logic [STATUS_W-1:0]    out_status;
  logic [ITEM_W-1:0]      out_removed;
  logic [COUNT_OUT_W-1:0] out_count;
  logic                   out_empty;

  assign new_item = s_axis_tdata[ITEM_W-1:0];
  assign new_prio = $signed(s_axis_tdata[ITEM_W +: PW]);

  for (genvar s = 1; s <= ITEMS; s++) begin : g_cell
    localparam int P = s / 2;
    localparam int L = 2 * s;
    localparam int R = 2 * s + 1;

    logic [ITEM_W-1:0]    p_item, l_item, r_item;
    logic signed [PW-1:0] p_prio, l_prio, r_prio;
    logic                 p_dn, l_up, r_up;

    if (s > 1) begin : g_par
      assign p_item = item_a[P];
      assign p_prio = prio_a[P];
      assign p_dn   = (s % 2 == 0) ? dnl_a[P] : dnr_a[P];
    end else begin : g_root
      assign p_item = '0;
      assign p_prio = '0;
      assign p_dn   = 1'b0;
    end

    if (L <= ITEMS) begin : g_left
      assign l_item = item_a[L];
      assign l_prio = prio_a[L];
      assign l_up   = up_a[L];
    end else begin : g_no_left
      assign l_item = '0;
      assign l_prio = '0;
      assign l_up   = 1'b0;
    end

    if (R <= ITEMS) begin : g_right
      assign r_item = item_a[R];
      assign r_prio = prio_a[R];
      assign r_up   = up_a[R];
    end else begin : g_no_right
      assign r_item = '0;
      assign r_prio = '0;
      assign r_up   = 1'b0;
    end

    imq_cell #(
      .SLOT  (s),
      .ITEMS (ITEMS),
      .PW    (PW)
    ) u_cell (
      .clk            (clk),
      .rst            (rst),
      .ctl            (ctl),
      .n              (count),
      .new_item       (new_item),
      .new_prio       (new_prio),
      .last_item_bus  (last_item_bus),
      .last_prio_bus  (last_prio_bus),
      .parent_item    (p_item),
      .parent_prio    (p_prio),
      .parent_dn_swap (p_dn),
      .left_item      (l_item),
      .left_prio      (l_prio),
      .left_up_swap   (l_up),
      .right_item     (r_item),
      .right_prio     (r_prio),
      .right_up_swap  (r_up),
      .item           (item_a[s]),
      .prio           (prio_a[s]),
      .tok            (tok_v[s-1]),
      .hit            (hit_v[s-1]),
      .stop           (stop_v[s-1]),
      .up_swap        (up_a[s]),
      .dn_swap_l      (dnl_a[s]),
      .dn_swap_r      (dnr_a[s]),
      .last_item      (last_item_a[s]),
      .last_prio      (last_prio_a[s])
    );
  end

  assign any_hit  = |hit_v;
  assign any_stop = |stop_v;

  // only the slot at the current count drives a nonzero value
  always_comb begin
    last_item_bus = '0;
    last_prio_bus = '0;
    for (int s = 1; s <= ITEMS; s++) begin
      last_item_bus = last_item_bus | last_item_a[s];
      last_prio_bus = last_prio_bus | last_prio_a[s];
    end
  end

  imq_ctrl #(
    .ITEMS    (ITEMS),
    .CAPACITY (CAPACITY)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_axis_tvalid),
    .in_ready    (s_axis_tready),
    .in_func     (s_axis_tuser),
    .in_item     (new_item),
    .any_hit     (any_hit),
    .any_stop    (any_stop),
    .top_item    (item_a[1]),
    .ctl         (ctl),
    .count       (count),
    .out_valid   (m_axis_tvalid),
    .out_ready   (m_axis_tready),
    .out_status  (out_status),
    .out_removed (out_removed),
    .out_count   (out_count),
    .out_empty   (out_empty)
  );

  assign m_axis_tuser = out_status;
  assign m_axis_tdata = {
    (M_DATA_W - ITEM_W - COUNT_OUT_W - 1)'(0), out_empty, out_count, out_removed
  };

  `IMQ_ASSERT(a_tok_onehot0, 1'b1, $onehot0(tok_v), "more than one sift token")
  `IMQ_ASSERT(a_tok_active, ctl.up || ctl.dn, $onehot(tok_v), "sift step without token")

endmodule
